/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define MIIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle implication built on the one above.
`define MIIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    `MIIR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/miir_pkg.sv */
// Types and constants of the multichannel IIR filter.
package miir_pkg;

    localparam int ORDER     = 4;
    localparam int MAX_ORDER = 4;
    localparam int CHANNELS  = 64;
    localparam int CH_AW     = $clog2(CHANNELS);

    localparam int COEF_W    = 32;
    localparam int SAMPLE_W  = 24;
    localparam int CHAN_W    = 6;
    localparam int STATE_W   = 48;
    localparam int ROW_W     = ORDER * STATE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [COEF_W-1:0] B0_RESET = 32'h0800_0000;

    localparam logic signed [SAMPLE_W-1:0] Y_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] Y_MIN = 24'sh80_0000;
    localparam logic signed [COEF_W-1:0]   YF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0]   YF_MIN = 32'sh8000_0000;
    localparam logic signed [STATE_W-1:0]  Z_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [STATE_W-1:0]  Z_MIN = 48'sh8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_B0_B1 = 3'd0,
        CFG_NUM_B2_B3 = 3'd1,
        CFG_NUM_B4    = 3'd2,
        CFG_DEN_A1_A2 = 3'd3,
        CFG_DEN_A3_A4 = 3'd4,
        CFG_SEED_01   = 3'd5,
        CFG_SEED_23   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_FB,
        ST_WB
    } t_state;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       restart;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } t_out_beat;

    // a[k] holds a_(k+1); zi[k] holds zi_k
    typedef struct packed {
        logic [MAX_ORDER:0][COEF_W-1:0]   b;
        logic [MAX_ORDER-1:0][COEF_W-1:0] a;
        logic [MAX_ORDER-1:0][COEF_W-1:0] zi;
    } t_coefs;

endpackage

/* rtl/multichannel_iir_filter_core.sv */
// Multichannel IIR filter core, transposed direct form II, state in one row-per-channel RAM.
//
//  port group   | direction | handshake               | beat
//  -------------+-----------+-------------------------+---------------------
//  in           | input     | i_in_valid / o_in_ready | t_in_beat
//  out          | output    | o_out_valid/ i_out_ready| t_out_beat
//  cfg          | input     | i_cfg_we (no wait)      | idx + 64-bit data
//
// One item at a time: accept + RAM read, x times b and zi, output and
// feedback sum, feedback times a, state write-back. The serial chain through
// the channel's state row (read, two multiply ranks, write) keeps the next item out until write-back.
// Reset clears the FSM, the output register and the per-channel seeded bits;
// the state RAM is not cleared, a channel is seeded on its first sample.
// The result waits in the output register while the next item is taken;
// write-back holds if that register is still full.
module multichannel_iir_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  miir_pkg::t_in_beat                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output miir_pkg::t_out_beat                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [miir_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [miir_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ORD  = miir_pkg::ORDER;
    localparam int ZW   = miir_pkg::STATE_W;

    miir_pkg::t_coefs    coefs;
    miir_pkg::t_state    r_state, n_state;

    miir_pkg::t_in_beat  r_in;
    logic                in_acc;
    logic                out_load;

    logic [miir_pkg::ROW_W-1:0] mem [miir_pkg::CHANNELS];
    logic [miir_pkg::ROW_W-1:0] r_rd_row;
    logic [miir_pkg::ROW_W-1:0] n_row;
    logic [miir_pkg::CH_AW-1:0] ch_idx;

    logic [miir_pkg::CHANNELS-1:0] r_seeded;
    logic                          seed;

    logic signed [55:0] r_pb [ORD+1];
    logic signed [55:0] r_pz [ORD];
    logic signed [63:0] r_pa [ORD];

    logic signed [55:0] seed_rnd [ORD];
    logic signed [ZW-1:0] z_eff [ORD];
    logic signed [ZW-1:0] r_z   [ORD];

    logic signed [59:0] t_sum;
    logic signed [59:0] y_full;
    logic signed [59:0] yf_full;
    logic signed [miir_pkg::SAMPLE_W-1:0] n_y, r_y;
    logic                                 n_sat, r_sat;
    logic signed [miir_pkg::COEF_W-1:0]   n_yf, r_yf;

    logic signed [55:0] fb_q  [ORD];
    logic signed [57:0] fb_d  [ORD];
    logic signed [57:0] fb_r  [ORD];
    logic signed [48:0] z_sum [ORD];
    logic signed [ZW-1:0] z_new [ORD];

    logic                 r_out_valid;
    miir_pkg::t_out_beat  r_out;

    miir_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (coefs)
    );

    assign ch_idx   = r_in.channel[miir_pkg::CH_AW-1:0];
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == miir_pkg::ST_WB) && (!r_out_valid || i_out_ready);
    assign seed     = r_in.restart || !r_seeded[ch_idx];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= miir_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            miir_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = miir_pkg::ST_MUL;
                end
            end
            miir_pkg::ST_MUL: n_state = miir_pkg::ST_SUM;
            miir_pkg::ST_SUM: n_state = miir_pkg::ST_FB;
            miir_pkg::ST_FB:  n_state = miir_pkg::ST_WB;
            miir_pkg::ST_WB: begin
                if (out_load) begin
                    n_state = miir_pkg::ST_IDLE;
                end
            end
            default: n_state = miir_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    // state RAM, one row of ORDER states per channel
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_row <= mem[i_in.channel[miir_pkg::CH_AW-1:0]];
        end
        if (out_load) begin
            mem[ch_idx] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= '0;
        end else if (r_state == miir_pkg::ST_SUM) begin
            r_seeded[ch_idx] <= 1'b1;
        end
    end

    // x products
    always_ff @(posedge i_clk) begin
        if (r_state == miir_pkg::ST_MUL) begin
            for (int k = 0; k <= ORD; k++) begin
                r_pb[k] <= $signed(coefs.b[k]) * r_in.sample_in;
            end
            for (int k = 0; k < ORD; k++) begin
                r_pz[k] <= $signed(coefs.zi[k]) * r_in.sample_in;
            end
        end
    end

    // output and feedback value
    always_comb begin
        for (int k = 0; k < ORD; k++) begin
            seed_rnd[k] = (r_pz[k] + 56'sd1024) >>> 11;
            z_eff[k]    = seed ? seed_rnd[k][ZW-1:0]
                               : $signed(r_rd_row[k*ZW +: ZW]);
        end
        t_sum   = 60'(r_pb[0]) + (60'(z_eff[0]) <<< 11);
        y_full  = (t_sum + 60'sd67108864) >>> 27;
        yf_full = (t_sum + 60'sd262144) >>> 19;
        n_sat   = (y_full > 60'(miir_pkg::Y_MAX)) || (y_full < 60'(miir_pkg::Y_MIN));
        if (y_full > 60'(miir_pkg::Y_MAX)) begin
            n_y = miir_pkg::Y_MAX;
        end else if (y_full < 60'(miir_pkg::Y_MIN)) begin
            n_y = miir_pkg::Y_MIN;
        end else begin
            n_y = y_full[miir_pkg::SAMPLE_W-1:0];
        end
        if (yf_full > 60'(miir_pkg::YF_MAX)) begin
            n_yf = miir_pkg::YF_MAX;
        end else if (yf_full < 60'(miir_pkg::YF_MIN)) begin
            n_yf = miir_pkg::YF_MIN;
        end else begin
            n_yf = yf_full[miir_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == miir_pkg::ST_SUM) begin
            r_z   <= z_eff;
            r_y   <= n_y;
            r_sat <= n_sat;
            r_yf  <= n_yf;
        end
    end

    // feedback products
    always_ff @(posedge i_clk) begin
        if (r_state == miir_pkg::ST_FB) begin
            for (int k = 0; k < ORD; k++) begin
                r_pa[k] <= $signed(coefs.a[k]) * r_yf;
            end
        end
    end

    // state update, z_(k+1) is the value from before this item
    always_comb begin
        for (int k = 0; k < ORD; k++) begin
            fb_q[k]  = 56'(r_pa[k] >>> 8);
            fb_d[k]  = 58'(r_pb[k+1]) - 58'(fb_q[k]);
            fb_r[k]  = (fb_d[k] + 58'sd1024) >>> 11;
            if (k + 1 < ORD) begin
                z_sum[k] = 49'(fb_r[k]) + 49'(r_z[(k+1) % ORD]);
            end else begin
                z_sum[k] = 49'(fb_r[k]);
            end
            if (z_sum[k] > 49'(miir_pkg::Z_MAX)) begin
                z_new[k] = miir_pkg::Z_MAX;
            end else if (z_sum[k] < 49'(miir_pkg::Z_MIN)) begin
                z_new[k] = miir_pkg::Z_MIN;
            end else begin
                z_new[k] = z_sum[k][ZW-1:0];
            end
            n_row[k*ZW +: ZW] = z_new[k];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.channel_out <= r_in.channel;
            r_out.sample_out  <= r_y;
            r_out.saturated   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/miir_cfg_regs.sv */
// Coefficient and seed-factor register bank with write decode.
module miir_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [miir_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [miir_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output miir_pkg::t_coefs                     o_coefs
);

    logic [63:0] r_b01;
    logic [63:0] r_b23;
    logic [31:0] r_b4;
    logic [63:0] r_a12;
    logic [63:0] r_a34;
    logic [63:0] r_z01;
    logic [63:0] r_z23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b01 <= {32'd0, miir_pkg::B0_RESET};
            r_b23 <= '0;
            r_b4  <= '0;
            r_a12 <= '0;
            r_a34 <= '0;
            r_z01 <= '0;
            r_z23 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                miir_pkg::CFG_NUM_B0_B1: r_b01 <= i_cfg_data;
                miir_pkg::CFG_NUM_B2_B3: r_b23 <= i_cfg_data;
                miir_pkg::CFG_NUM_B4:    r_b4  <= i_cfg_data[31:0];
                miir_pkg::CFG_DEN_A1_A2: r_a12 <= i_cfg_data;
                miir_pkg::CFG_DEN_A3_A4: r_a34 <= i_cfg_data;
                miir_pkg::CFG_SEED_01:   r_z01 <= i_cfg_data;
                miir_pkg::CFG_SEED_23:   r_z23 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_coefs.b[0]  = r_b01[31:0];
        o_coefs.b[1]  = r_b01[63:32];
        o_coefs.b[2]  = r_b23[31:0];
        o_coefs.b[3]  = r_b23[63:32];
        o_coefs.b[4]  = r_b4;
        o_coefs.a[0]  = r_a12[31:0];
        o_coefs.a[1]  = r_a12[63:32];
        o_coefs.a[2]  = r_a34[31:0];
        o_coefs.a[3]  = r_a34[63:32];
        o_coefs.zi[0] = r_z01[31:0];
        o_coefs.zi[1] = r_z01[63:32];
        o_coefs.zi[2] = r_z23[31:0];
        o_coefs.zi[3] = r_z23[63:32];
    end

endmodule

/* rtl/miir_checker.sv */
// Port-level checker for the filter core, bound to the top level.
`include "assert_macros.svh"

module miir_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input miir_pkg::t_out_beat  o_out
);

    `MIIR_ASSERT_NEXT(a_out_valid_held, o_out_valid && !i_out_ready, o_out_valid, "out valid dropped while stalled")
    `MIIR_ASSERT_NEXT(a_out_beat_held, o_out_valid && !i_out_ready, $stable(o_out), "out beat changed while stalled")
    `MIIR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready still high after accept")
    `MIIR_ASSERT_NEXT(a_no_instant_result, i_in_valid && o_in_ready, !$rose(o_out_valid), "result rose one cycle after accept")

endmodule

bind multichannel_iir_filter_core miir_checker u_miir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the multichannel IIR filter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import miir_pkg::*;

    localparam int CFG_REGS        = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int RAND_PHASES     = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 2000;

    typedef enum int {MIX_MILD, MIX_WILD, MIX_TOP, MIX_BOTTOM} t_coef_mix;

    // Tracks coefficient registers and per-channel delay lines, predicts each filtered beat.
    class iir_scoreboard;
        logic [CFG_DATA_W-1:0] regs [CFG_REGS];
        longint                zline [CHANNELS][ORDER];
        bit                    seeded [CHANNELS];
        t_out_beat             filtered_due [$];
        int                    mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[CFG_NUM_B0_B1] = {32'b0, B0_RESET};
            foreach (seeded[i]) seeded[i] = 1'b0;
            foreach (zline[c, k]) zline[c][k] = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx < CFG_REGS)
                regs[idx] = (idx == CFG_NUM_B4) ? {32'b0, data[31:0]} : data;
        endfunction

        function longint coef(int r, int upper);
            return longint'($signed(upper ? regs[r][63:32] : regs[r][31:0]));
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void take_sample(t_in_beat beat);
            longint    cb [ORDER+1];
            longint    ca [ORDER];
            longint    zi [ORDER];
            longint    x, t, y, yf, p, q, nxt;
            int        c;
            bit        clip;
            t_out_beat want;
            c = beat.channel % CHANNELS;
            x = beat.sample_in;
            for (int k = 0; k <= ORDER; k++) cb[k] = coef(CFG_NUM_B0_B1 + k / 2, k % 2);
            for (int k = 0; k < ORDER; k++) begin
                ca[k] = coef(CFG_DEN_A1_A2 + k / 2, k % 2);
                zi[k] = coef(CFG_SEED_01 + k / 2, k % 2);
            end
            if (beat.restart || !seeded[c]) begin
                for (int k = 0; k < ORDER; k++) zline[c][k] = rnd(zi[k] * x, 11);
                seeded[c] = 1'b1;
            end
            t    = cb[0] * x + zline[c][0] * 2048;
            y    = rnd(t, 27);
            clip = (y > Y_MAX) || (y < Y_MIN);
            y    = clamp(y, Y_MIN, Y_MAX);
            yf   = clamp(rnd(t, 19), YF_MIN, YF_MAX);
            // zline[k+1] still holds the pre-update value when stage k reads it
            for (int k = 0; k < ORDER; k++) begin
                p   = cb[k+1] * x;
                q   = (ca[k] * yf) >>> 8;
                nxt = (k + 1 < ORDER) ? zline[c][k+1] : 0;
                zline[c][k] = clamp(rnd(p - q, 11) + nxt, Z_MIN, Z_MAX);
            end
            want.channel_out = beat.channel;
            want.sample_out  = y[SAMPLE_W-1:0];
            want.saturated   = clip;
            filtered_due.push_back(want);
        endfunction

        function void check_filtered(t_out_beat got);
            t_out_beat want;
            if (filtered_due.size() == 0) begin
                $error("unexpected output beat: channel_out %0d sample_out %0d",
                       got.channel_out, got.sample_out);
                mismatches++;
                return;
            end
            want = filtered_due.pop_front();
            if (got.channel_out !== want.channel_out) begin
                $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
                mismatches++;
            end
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;

    iir_scoreboard sb = new();

    multichannel_iir_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [COEF_W-1:0] pick_coef(t_coef_mix mix);
        case (mix)
            MIX_MILD:  return COEF_W'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
            MIX_WILD:  return $urandom;
            MIX_TOP:   return 32'h7FFF_FFFF;
            default:   return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return Y_MAX;
                    1:       return Y_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3, 4: return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
            default:    return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly a few busy channels so the delay lines evolve; restart now and then
    function automatic t_in_beat random_beat();
        t_in_beat beat;
        beat.channel   = ($urandom_range(9) < 7) ? CHAN_W'($urandom_range(3))
                                                 : CHAN_W'($urandom_range(63));
        beat.sample_in = random_sample();
        beat.restart   = ($urandom_range(15) == 0);
        return beat;
    endfunction

    // all coefficient registers, then a write to an unmapped index that must be ignored
    task automatic load_config(t_coef_mix mix);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_IDX_W-1:0]  idx;
        for (int i = 0; i <= CFG_REGS; i++) begin
            idx = (i < CFG_REGS) ? CFG_IDX_W'(i) : CFG_SPARE_IDX;
            if (idx == CFG_NUM_B4)
                data = {32'($urandom), pick_coef(mix)};
            else if (i < CFG_REGS)
                data = {pick_coef(mix), pick_coef(mix)};
            else
                data = {$urandom, $urandom};
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            sb.write_reg(idx, data);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_sample(t_in_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(beat);
    endtask

    task automatic settle();
        while (sb.filtered_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_filtered(o_out);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 51;

        // reset coefficients: unity pass-through, first beat per channel seeds
        offer_sample(t_in_beat'{6'd0,  Y_MAX,     1'b0});
        offer_sample(t_in_beat'{6'd63, Y_MIN,     1'b0});
        offer_sample(t_in_beat'{6'd0,  24'sd0,    1'b1});
        offer_sample(t_in_beat'{6'd1,  -24'sd1,   1'b0});
        offer_sample(t_in_beat'{6'd1,  24'sd1,    1'b1});
        offer_sample(t_in_beat'{6'd42, 24'h55AA55, 1'b0});
        offer_sample(t_in_beat'{6'd21, 24'hAA55AA, 1'b1});
        i_in_valid <= 1'b0;
        settle();

        // full-scale coefficients: output clips both ways, feedback saturates
        load_config(MIX_TOP);
        offer_sample(t_in_beat'{6'd2,  Y_MAX,   1'b0});
        offer_sample(t_in_beat'{6'd3,  Y_MIN,   1'b0});
        offer_sample(t_in_beat'{6'd2,  Y_MIN,   1'b1});
        offer_sample(t_in_beat'{6'd2,  24'sd0,  1'b0});
        offer_sample(t_in_beat'{6'd3,  24'sd1,  1'b0});
        offer_sample(t_in_beat'{6'd3,  -24'sd1, 1'b1});
        offer_sample(t_in_beat'{6'd63, Y_MAX,   1'b1});
        offer_sample(t_in_beat'{6'd0,  Y_MAX,   1'b0});
        i_in_valid <= 1'b0;

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            case (phase / 2)
                0: begin send_idle_pct = 35; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_config(t_coef_mix'(phase % 4));
            // long output stall while input keeps coming
            if (phase == 1 || phase == RAND_PHASES - 1) hold_requests++;
            repeat (ITEMS_PER_PHASE) offer_sample(random_beat());
            i_in_valid <= 1'b0;
        end

        settle();
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
